[src/bsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned CMD_W           = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned FILL_W          = 4;
  localparam int unsigned DEF_STACK_DEPTH = 8;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_REPLACE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_OVERFLOW = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_NOTFOUND = 2'd3
  } status_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_CMP,
    OP_WRITE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    word_t    value;
    word_t    match;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[src/bsr_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One stack slot. The cell nearer the top sits "up", the older one "down".
module bsr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsr_pkg::cell_ctrl_t ctrl_i,
  input  logic                sel_i,
  input  bsr_pkg::word_t      up_data_i,
  input  logic                up_vld_i,
  input  bsr_pkg::word_t      dn_data_i,
  input  logic                dn_vld_i,
  output bsr_pkg::word_t      data_o,
  output logic                vld_o,
  output logic                hit_o
);
  import bsr_pkg::*;

  word_t data_q, data_d;
  logic  vld_q, vld_d;
  logic  hit_q, hit_d;

  always_comb begin
    data_d = data_q;
    vld_d  = vld_q;
    hit_d  = hit_q;
    case (ctrl_i.op)
      OP_PUSH: begin
        data_d = up_data_i;
        vld_d  = up_vld_i;
      end
      OP_POP: begin
        data_d = dn_data_i;
        vld_d  = dn_vld_i;
      end
      OP_CMP: begin
        hit_d = vld_q && (data_q == ctrl_i.match);
      end
      OP_WRITE: begin
        if (sel_i) begin
          data_d = ctrl_i.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign vld_o  = vld_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire

[src/bsr_pick.sv]
`timescale 1ns / 1ps
`default_nettype none

// Select the oldest matching cell: the highest set index of the hit vector.
module bsr_pick #(
  parameter int unsigned STACK_DEPTH = bsr_pkg::DEF_STACK_DEPTH
) (
  input  logic [STACK_DEPTH-1:0] hit_i,
  output logic [STACK_DEPTH-1:0] sel_o,
  output logic                   any_o
);
  import bsr_pkg::*;

  logic [STACK_DEPTH-1:0] rev;
  logic [STACK_DEPTH-1:0] rev_low;

  always_comb begin
    for (int unsigned i = 0; i < STACK_DEPTH; i++) begin
      rev[i] = hit_i[STACK_DEPTH-1-i];
    end
  end

  // Isolate lowest set bit of the reversed vector.
  assign rev_low = rev & (~rev + {{(STACK_DEPTH-1){1'b0}}, 1'b1});

  always_comb begin
    for (int unsigned i = 0; i < STACK_DEPTH; i++) begin
      sel_o[i] = rev_low[STACK_DEPTH-1-i];
    end
  end

  assign any_o = |hit_i;

endmodule

`default_nettype wire

[src/bounded_stack_with_replace.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake                    | Payload
// --------+-----------+------------------------------+-----------------------------------
// in      | input     | in_valid_i / in_ready_o      | cmd_i, value_i, match_value_i
// out     | output    | out_valid_o / out_ready_i    | status_o, data_o, fill_level_o
//
// Push, pop and peek results are registered at the edge that accepts the
// request. Replace has every cell compare at the accepting edge; then, in the
// scan state, once the output register is free, the oldest matching cell is picked and rewritten.
// One request is in flight at a time; a new request is taken while the output
// register is empty or being drained in the same cycle.
// Reset clears the fill count, the cell valid bits and the output register;
// cell data is undefined until pushed. A stalled output holds the block.
module bounded_stack_with_replace #(
  parameter int unsigned STACK_DEPTH = bsr_pkg::DEF_STACK_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bsr_pkg::CMD_W-1:0]       cmd_i,
  input  bsr_pkg::word_t                  value_i,
  input  bsr_pkg::word_t                  match_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bsr_pkg::STATUS_W-1:0]    status_o,
  output bsr_pkg::word_t                  data_o,
  output logic [bsr_pkg::FILL_W-1:0]      fill_level_o
);
  import bsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  word_t              value_q;
  logic               out_valid_q;
  status_e            status_q;
  word_t              data_q;
  logic [FILL_W-1:0]  fill_q;

  // Chain of cells; cell 0 holds the top entry.
  cell_ctrl_t             ctrl;
  word_t                  cell_data [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] cell_vld;
  logic [STACK_DEPTH-1:0] cell_hit;
  logic [STACK_DEPTH-1:0] cell_sel;
  logic                   hit_any;

  logic accept;
  logic out_free;
  logic out_load;
  logic full;
  logic empty;

  // Report the low bits of the count, zero-extended where the count is narrow.
  function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+FILL_W-1:0] ext;
    ext = {{FILL_W{1'b0}}, cnt};
    return ext[FILL_W-1:0];
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = cell_vld[STACK_DEPTH-1];
  assign empty      = !cell_vld[0];

  // A result enters the output register on a direct command or at the end of
  // a replace scan.
  assign out_load   = (accept && (cmd_e'(cmd_i) != CMD_REPLACE)) ||
                      (state_q == S_SCAN && out_free);

  // Broadcast operation to the chain.
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.value = value_i;
    ctrl.match = match_value_i;
    if (accept) begin
      case (cmd_e'(cmd_i))
        CMD_PUSH:    if (!full)  ctrl.op = OP_PUSH;
        CMD_POP:     if (!empty) ctrl.op = OP_POP;
        CMD_REPLACE: ctrl.op = OP_CMP;
        default:     ctrl.op = OP_HOLD;
      endcase
    end else if (state_q == S_SCAN && out_free) begin
      ctrl.op    = OP_WRITE;
      ctrl.value = value_q;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t up_data, dn_data;
    logic  up_vld, dn_vld;

    if (i == 0) begin : g_top
      assign up_data = value_i;
      assign up_vld  = 1'b1;
    end else begin : g_mid_up
      assign up_data = cell_data[i-1];
      assign up_vld  = cell_vld[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign dn_data = '0;
      assign dn_vld  = 1'b0;
    end else begin : g_mid_dn
      assign dn_data = cell_data[i+1];
      assign dn_vld  = cell_vld[i+1];
    end

    bsr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .sel_i     (cell_sel[i]),
      .up_data_i (up_data),
      .up_vld_i  (up_vld),
      .dn_data_i (dn_data),
      .dn_vld_i  (dn_vld),
      .data_o    (cell_data[i]),
      .vld_o     (cell_vld[i]),
      .hit_o     (cell_hit[i])
    );
  end

  bsr_pick #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_pick (
    .hit_i (cell_hit),
    .sel_o (cell_sel),
    .any_o (hit_any)
  );

  // Control and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      value_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STS_OK;
      data_q      <= '0;
      fill_q      <= '0;
    end else begin
      // load a fresh result, or drain the output register when taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (cmd_e'(cmd_i))
              CMD_PUSH: begin
                data_q <= '0;
                if (full) begin
                  status_q <= STS_OVERFLOW;
                  fill_q   <= fill_of(count_q);
                end else begin
                  status_q <= STS_OK;
                  count_q  <= count_q + CNT_W'(1);
                  fill_q   <= fill_of(count_q + CNT_W'(1));
                end
              end
              CMD_POP: begin
                if (empty) begin
                  status_q <= STS_EMPTY;
                  data_q   <= '0;
                  fill_q   <= fill_of(count_q);
                end else begin
                  status_q <= STS_OK;
                  data_q   <= cell_data[0];
                  count_q  <= count_q - CNT_W'(1);
                  fill_q   <= fill_of(count_q - CNT_W'(1));
                end
              end
              CMD_PEEK: begin
                fill_q <= fill_of(count_q);
                if (empty) begin
                  status_q <= STS_EMPTY;
                  data_q   <= '0;
                end else begin
                  status_q <= STS_OK;
                  data_q   <= cell_data[0];
                end
              end
              CMD_REPLACE: begin
                // hold the new word for the rewrite cycle
                value_q <= value_i;
                state_q <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (out_free) begin
            status_q <= hit_any ? STS_OK : STS_NOTFOUND;
            data_q   <= '0;
            fill_q   <= fill_of(count_q);
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_o       = data_q;
  assign fill_level_o = fill_q;

  // Valid bits of the chain must track the fill count.
  a_count_matches_cells: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == int'(count_q)
  ) else $error("cell valid bits disagree with fill count");

  // Occupied cells form a contiguous run from the top.
  a_cells_contiguous: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ((cell_vld + {{(STACK_DEPTH-1){1'b0}}, 1'b1}) & cell_vld) == '0
  ) else $error("cell valid bits are not contiguous");

  // At most one cell is rewritten by a replace.
  a_single_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> $onehot0(cell_sel)
  ) else $error("replace selects more than one cell");

  // A replace always leaves the scan state with a result once output is free.
  a_scan_finishes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && out_free) |=> (out_valid_q && state_q == S_IDLE)
  ) else $error("replace result not produced");

endmodule

`default_nettype wire

[sim/tb_bounded_stack_with_replace.sv]
`timescale 1ns / 1ps

// Self-checking bench for the bounded stack with in-place replace.
// Each accepted request updates a local stack image and queues the result
// that the block must return. Returned results are compared in order, field
// by field.
module tb_bounded_stack_with_replace;
  import bsr_pkg::*;

  localparam int unsigned DEPTH       = DEF_STACK_DEPTH;
  localparam int unsigned RAND_ITEMS  = 1525;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned HIST_LEN    = 16;

  typedef struct packed {
    status_e           status;
    word_t             data;
    logic [FILL_W-1:0] fill;
  } result_t;

  // Per-request side info: a hand-written result overrides the stack image.
  typedef struct packed {
    logic    typed;
    result_t res;
  } request_note_t;

  typedef struct packed {
    cmd_e              cmd;
    word_t             value;
    word_t             match;
    logic              typed;
    status_e           status;
    word_t             data;
    logic [FILL_W-1:0] fill;
  } dir_row_t;

  // Directed opening: empty-stack errors, fill to the top with extreme words
  // and a duplicate, overflow when full, replace hitting only the lowest match,
  // replace without a match, then drain to show the rewritten entries.
  localparam int unsigned DIR_ROWS = 25;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_POP,     32'h0,        32'h0,        1'b1, STS_EMPTY,    32'h0,        4'd0},
    '{CMD_PEEK,    32'h0,        32'h0,        1'b1, STS_EMPTY,    32'h0,        4'd0},
    '{CMD_REPLACE, 32'h1,        32'h0,        1'b1, STS_NOTFOUND, 32'h0,        4'd0},
    '{CMD_PUSH,    32'h7FFFFFFF, 32'h0,        1'b1, STS_OK,       32'h0,        4'd1},
    '{CMD_PEEK,    32'h0,        32'h0,        1'b1, STS_OK,       32'h7FFFFFFF, 4'd1},
    '{CMD_PUSH,    32'h80000000, 32'hFFFFFFFF, 1'b1, STS_OK,       32'h0,        4'd2},
    '{CMD_PUSH,    32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, STS_OK,       32'h0,        4'd3},
    '{CMD_PUSH,    32'h0,        32'h0,        1'b1, STS_OK,       32'h0,        4'd4},
    '{CMD_PUSH,    32'h5,        32'h0,        1'b1, STS_OK,       32'h0,        4'd5},
    '{CMD_PUSH,    32'h5,        32'h0,        1'b1, STS_OK,       32'h0,        4'd6},
    '{CMD_PUSH,    32'h55555555, 32'hAAAAAAAA, 1'b1, STS_OK,       32'h0,        4'd7},
    '{CMD_PUSH,    32'hAAAAAAAA, 32'h55555555, 1'b1, STS_OK,       32'h0,        4'd8},
    '{CMD_PUSH,    32'h1,        32'h0,        1'b1, STS_OVERFLOW, 32'h0,        4'd8},
    '{CMD_REPLACE, 32'h9,        32'h5,        1'b1, STS_OK,       32'h0,        4'd8},
    '{CMD_REPLACE, 32'h12345678, 32'h5,        1'b1, STS_OK,       32'h0,        4'd8},
    '{CMD_REPLACE, 32'h7,        32'h5,        1'b1, STS_NOTFOUND, 32'h0,        4'd8},
    '{CMD_REPLACE, 32'hFFFFFFFE, 32'h80000000, 1'b1, STS_OK,       32'h0,        4'd8},
    '{CMD_POP,     32'h0,        32'h0,        1'b1, STS_OK,       32'hAAAAAAAA, 4'd7},
    '{CMD_POP,     32'h0,        32'h0,        1'b1, STS_OK,       32'h55555555, 4'd6},
    '{CMD_POP,     32'h0,        32'h0,        1'b0, STS_OK,       32'h0,        4'd0},
    '{CMD_POP,     32'h0,        32'h0,        1'b0, STS_OK,       32'h0,        4'd0},
    '{CMD_POP,     32'h0,        32'h0,        1'b1, STS_OK,       32'h0,        4'd3},
    '{CMD_POP,     32'h0,        32'h0,        1'b1, STS_OK,       32'hFFFFFFFF, 4'd2},
    '{CMD_POP,     32'h0,        32'h0,        1'b0, STS_OK,       32'h0,        4'd0},
    '{CMD_POP,     32'h0,        32'h0,        1'b1, STS_OK,       32'h7FFFFFFF, 4'd0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i         = '0;
  word_t               value_i       = '0;
  word_t               match_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b1;
  logic [STATUS_W-1:0] status_o;
  word_t               data_o;
  logic [FILL_W-1:0]   fill_level_o;

  // Local image of the stack, advanced once per accepted request.
  word_t               stack_mem [DEPTH];
  int unsigned         stack_cnt;

  request_note_t       request_notes[$];
  result_t             awaited_results[$];
  int unsigned         fail_cnt;
  int unsigned         cycle_cnt;
  bit                  quiet;        // set for the idle-free tail of the run
  int unsigned         in_idle_pct;

  bounded_stack_with_replace #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .match_value_i(match_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .data_o       (data_o),
    .fill_level_o (fill_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one command to the stack image and return the result it produces.
  // Replace scans from the bottom, so only the lowest equal entry changes.
  function automatic result_t stack_apply(cmd_e c, word_t v, word_t m);
    result_t r;
    int      hit;
    r.status = STS_OK;
    r.data   = '0;
    hit      = -1;
    case (c)
      CMD_PUSH: begin
        if (stack_cnt >= DEPTH) begin
          r.status = STS_OVERFLOW;
        end else begin
          stack_mem[stack_cnt] = v;
          stack_cnt++;
        end
      end
      CMD_POP: begin
        if (stack_cnt == 0) begin
          r.status = STS_EMPTY;
        end else begin
          stack_cnt--;
          r.data = stack_mem[stack_cnt];
        end
      end
      CMD_PEEK: begin
        if (stack_cnt == 0) r.status = STS_EMPTY;
        else r.data = stack_mem[stack_cnt-1];
      end
      default: begin
        for (int i = 0; i < int'(stack_cnt); i++) begin
          if (hit < 0 && stack_mem[i] == m) hit = i;
        end
        if (hit < 0) r.status = STS_NOTFOUND;
        else stack_mem[hit] = v;
      end
    endcase
    r.fill = FILL_W'(stack_cnt);
    return r;
  endfunction

  // Bias words toward the extremes and a small set, so duplicates and
  // replace hits are common.
  function automatic word_t rand_word();
    case ($urandom_range(9))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return '0;
      3:       return '1;
      4, 5:    return word_t'($urandom_range(7));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Present one request, optionally after an idle burst, and hold it until
  // the handshake. Leave valid high afterwards so back-to-back requests flow.
  task automatic send_request(cmd_e c, word_t v, word_t m, request_note_t note);
    if (!quiet && in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    request_notes.push_back(note);
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    value_i       <= v;
    match_value_i <= m;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Watch both handshakes on the same edge that the block sees them.
  // Queue the expected result on request accept, check it on result accept.
  always @(posedge clk_i) begin : watch
    request_note_t note;
    result_t       predicted;
    result_t       seen;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        note      = request_notes.pop_front();
        predicted = stack_apply(cmd_e'(cmd_i), value_i, match_value_i);
        awaited_results.push_back(note.typed ? note.res : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        seen = '{status_e'(status_o), data_o, fill_level_o};
        if (awaited_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] result with none pending: status %0d data %h fill %0d",
                     $realtime, status_o, data_o, fill_level_o);
        end else begin
          predicted = awaited_results.pop_front();
          if (seen.status !== predicted.status || seen.data !== predicted.data ||
              seen.fill !== predicted.fill) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display({"[%0t] mismatch: status exp %0d got %0d, data exp %h got %h,",
                        " fill exp %0d got %0d"}, $realtime,
                       predicted.status, seen.status, predicted.data, seen.data,
                       predicted.fill, seen.fill);
          end
        end
      end
    end
  end

  // Stall the result side in bursts; the stall rate changes every so often,
  // including stretches with no stall at all.
  initial begin : drain_side
    int unsigned stall_pct;
    int unsigned left;
    stall_pct = 0;
    left      = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
        left = $urandom_range(200, 30);
      end
      left--;
      if (!quiet && stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Cap the run; a hung handshake ends here.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("bounded_stack_with_replace verification failed");
    $finish;
  end

  initial begin : stimulus
    request_note_t note;
    word_t         pushed_hist [HIST_LEN];
    int unsigned   hist_wr;
    int unsigned   mode_left;
    int unsigned   push_lim;
    int unsigned   pop_lim;
    int unsigned   peek_lim;
    int unsigned   roll;
    cmd_e          c;
    word_t         v;
    word_t         m;

    stack_cnt   = 0;
    fail_cnt    = 0;
    quiet       = 1'b0;
    in_idle_pct = 20;
    hist_wr     = 0;
    mode_left   = 0;
    push_lim    = 25;
    pop_lim     = 50;
    peek_lim    = 75;
    foreach (stack_mem[i]) stack_mem[i] = '0;
    foreach (pushed_hist[i]) pushed_hist[i] = '0;

    // Hold reset, then release it once for good.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      note.typed = dir_rows[i].typed;
      note.res   = '{dir_rows[i].status, dir_rows[i].data, dir_rows[i].fill};
      send_request(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].match, note);
    end

    // Random part in episodes: fill-heavy, drain-heavy, even mix and
    // replace-heavy, so the stack keeps crossing both empty and full.
    note = '0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (mode_left == 0) begin
        case ($urandom_range(3))
          0:       begin push_lim = 60; pop_lim = 75; peek_lim = 85; end
          1:       begin push_lim = 20; pop_lim = 75; peek_lim = 85; end
          2:       begin push_lim = 25; pop_lim = 50; peek_lim = 75; end
          default: begin push_lim = 35; pop_lim = 55; peek_lim = 65; end
        endcase
        case ($urandom_range(2))
          0:       in_idle_pct = 0;
          1:       in_idle_pct = 10;
          default: in_idle_pct = 35;
        endcase
        mode_left = $urandom_range(40, 10);
      end
      mode_left--;

      roll = $urandom_range(99);
      if (roll < push_lim)      c = CMD_PUSH;
      else if (roll < pop_lim)  c = CMD_POP;
      else if (roll < peek_lim) c = CMD_PEEK;
      else                      c = CMD_REPLACE;

      v = rand_word();
      // Match against recent push and replace words half the time to hit entries.
      case ($urandom_range(3))
        0, 1:    m = pushed_hist[$urandom_range(HIST_LEN-1)];
        2:       m = word_t'($urandom_range(7));
        default: m = rand_word();
      endcase
      if (c == CMD_PUSH || c == CMD_REPLACE) begin
        pushed_hist[hist_wr % HIST_LEN] = v;
        hist_wr++;
      end
      send_request(c, v, m, note);
    end

    // Drop valid, drain what is in flight, then idle before the final check.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (awaited_results.size() == 0);
    repeat (10) @(posedge clk_i);

    if (fail_cnt == 0 && awaited_results.size() == 0) begin
      $display("bounded_stack_with_replace verification clean");
    end else begin
      $display("bounded_stack_with_replace verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bsr_pkg.sv
src/bsr_cell.sv
src/bsr_pick.sv
src/bounded_stack_with_replace.sv
sim/tb_bounded_stack_with_replace.sv
